// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects a clock i_clk in scope; ASSERT_CLK also expects an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset only.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/v7d_pkg.sv
// ----------------------------------------------------------------------------
// v7d_pkg
// Shared widths, constants and register indexes of the 7-bit group decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package v7d_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned GROUP_W = 7;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [BYTE_W-1:0] GROUP_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0] MORE_FLAG  = 8'h80;

    // Group limits for the two widths
    localparam logic [COUNT_W-1:0] LIMIT_NARROW = 4'd5;
    localparam logic [COUNT_W-1:0] LIMIT_WIDE   = 4'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE   = 4'd1;

endpackage

// File: hw/rtl/varint_7bit_decoder_core.sv
// ----------------------------------------------------------------------------
// varint_7bit_decoder_core
// Little-endian 7-bit group decoder with 32/64-bit width and an optional
// sign-magnitude mapping (low bit is the sign).
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// input     i_in_valid / o_in_ready   i_data_byte
// output    o_out_valid / i_out_ready o_decoded_value, o_byte_count, o_overlong
// config    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte a cycle unless a final byte waits on a held result: a byte is held in
// the input register, then the gather logic folds it into the accumulator and,
// on a final byte, loads the result register.
// Reset is synchronous, clears the accumulator and both valid flags, and
// returns the modes to unsigned 64-bit.
// A held result stalls only final bytes; continuation bytes keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module varint_7bit_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [v7d_pkg::BYTE_W-1:0]          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [v7d_pkg::WORD_W-1:0]          o_decoded_value,
    output logic [v7d_pkg::COUNT_W-1:0]         o_byte_count,
    output logic                                o_overlong,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [v7d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic                                i_cfg_data
);

    // Configuration
    logic r_signed_mode;
    logic r_wide_mode;

    // Input register
    logic                          r_in_valid;
    logic [v7d_pkg::BYTE_W-1:0]    r_in_byte;

    // Gather state
    logic [v7d_pkg::WORD_W-1:0]    r_acc,   n_acc;
    logic [v7d_pkg::COUNT_W-1:0]   r_group, n_group;
    logic                          r_over,  n_over;

    // Result register
    logic                          r_out_valid;
    logic [v7d_pkg::WORD_W-1:0]    r_value, n_value;
    logic [v7d_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                          r_out_over;

    logic                          w_final;
    logic                          w_step;
    logic                          w_gather;
    logic [v7d_pkg::COUNT_W-1:0]   w_limit;
    logic [6:0]                    w_shift;
    logic [v7d_pkg::WORD_W-1:0]    w_group_ext;
    logic [v7d_pkg::WORD_W-1:0]    w_code;
    logic [v7d_pkg::WORD_W-1:0]    w_mag;
    logic [v7d_pkg::WORD_W-1:0]    w_mask;

    assign o_cfg_ready = 1'b1;

    // Step the held byte unless it ends a value and the result slot is full and not being taken
    assign w_final  = (r_in_byte & v7d_pkg::MORE_FLAG) == '0;
    assign w_step   = r_in_valid && (!w_final || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    assign w_limit  = r_wide_mode ? v7d_pkg::LIMIT_WIDE : v7d_pkg::LIMIT_NARROW;
    assign w_gather = r_group < w_limit;

    // Shift of 7 times the group index; only used while gathering (index <= 9)
    assign w_shift     = ({3'd0, r_group} << 3) - {3'd0, r_group};
    assign w_group_ext = {{(v7d_pkg::WORD_W-v7d_pkg::BYTE_W){1'b0}},
                          r_in_byte & v7d_pkg::GROUP_MASK};

    // Gather the group and advance the index
    always_comb begin
        n_acc   = r_acc;
        n_group = r_group;
        n_over  = r_over;
        if (w_gather) begin
            n_acc   = r_acc | (w_group_ext << w_shift[5:0]);
            n_group = r_group + 4'd1;
        end else begin
            n_over  = 1'b1;
        end
    end

    // Truncate, then in signed mode map the sign-magnitude code back to two's complement
    assign w_mask = r_wide_mode ? {v7d_pkg::WORD_W{1'b1}}
                                : {{(v7d_pkg::WORD_W/2){1'b0}}, {(v7d_pkg::WORD_W/2){1'b1}}};
    assign w_code = n_acc & w_mask;
    assign w_mag  = w_code >> 1;

    always_comb begin
        if (!r_signed_mode || !w_code[0]) begin
            n_value = r_signed_mode ? w_mag : w_code;
        end else if (w_code == {{(v7d_pkg::WORD_W-1){1'b0}}, 1'b1}) begin
            n_value = r_wide_mode ? {1'b1, {(v7d_pkg::WORD_W-1){1'b0}}}
                                  : {{(v7d_pkg::WORD_W/2){1'b0}}, 1'b1,
                                     {(v7d_pkg::WORD_W/2-1){1'b0}}};
        end else begin
            n_value = (~w_mag + {{(v7d_pkg::WORD_W-1){1'b0}}, 1'b1}) & w_mask;
        end
        n_count = (n_group < w_limit) ? n_group : w_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
            r_wide_mode   <= 1'b1;
            r_in_valid    <= 1'b0;
            r_acc         <= '0;
            r_group       <= '0;
            r_over        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Register writes; unknown indexes drop
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    v7d_pkg::REG_SIGNED_MODE: r_signed_mode <= i_cfg_data;
                    v7d_pkg::REG_WIDE_MODE:   r_wide_mode   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Hold or refill the input register
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            // Load a new result beat, or retire a taken one
            if (w_step && w_final) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Advance the gather state; a final beat clears it
            if (w_step) begin
                if (w_final) begin
                    r_acc       <= '0;
                    r_group     <= '0;
                    r_over      <= 1'b0;
                end else begin
                    r_acc   <= n_acc;
                    r_group <= n_group;
                    r_over  <= n_over;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (w_step && w_final) begin
            r_value    <= n_value;
            r_count    <= n_count;
            r_out_over <= n_over;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_decoded_value = r_value;
    assign o_byte_count    = r_count;
    assign o_overlong      = r_out_over;

endmodule

// File: hw/rtl/v7d_checker.sv
// ----------------------------------------------------------------------------
// v7d_checker
// Port-level checks for the 7-bit group decoder, bound to the decoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module v7d_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [v7d_pkg::WORD_W-1:0]    o_decoded_value,
    input logic [v7d_pkg::COUNT_W-1:0]   o_byte_count,
    input logic                          o_overlong,
    input logic                          o_cfg_ready
);

    // A stalled result beat holds
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_decoded_value) && $stable(o_byte_count) && $stable(o_overlong), "result changed while stalled")

    // No result straight after reset
    `ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // Count stays within one and ten
    `ASSERT_CLK(a_count_range, o_out_valid |-> o_byte_count >= 4'd1 && o_byte_count <= 4'd10, "byte count out of range")

    // Dropped bytes only once a width limit was reached
    `ASSERT_CLK(a_overlong_count, o_out_valid && o_overlong |-> o_byte_count >= v7d_pkg::LIMIT_NARROW, "overlong without full count")

    // Register writes never stall
    `ASSERT_CLK(a_cfg_ready, o_cfg_ready, "configuration port stalled")

endmodule

bind varint_7bit_decoder_core v7d_checker u_v7d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_decoded_value (o_decoded_value),
    .o_byte_count    (o_byte_count),
    .o_overlong      (o_overlong),
    .o_cfg_ready     (o_cfg_ready)
);
